// ===== design/ddm_pkg.sv =====
`default_nettype none

package ddm_pkg;

    // Joystick full scale and PWM remap window
    localparam int FULL_SCALE = 1023;
    localparam int PWM_MIN    = 600;
    localparam int PWM_MAX    = 1023;
    localparam int REMAP_SPAN = PWM_MAX - PWM_MIN;

    // Field and bus widths
    localparam int AXIS_W     = 11;
    localparam int MAG_W      = 10;
    localparam int CFG_W      = 10;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 24;

    // Pivot weight in unsigned Q16, one extra bit to hold 1.0
    localparam int Q_FRAC     = 16;
    localparam int Q_W        = Q_FRAC + 1;

    // Reciprocal of the full scale: floor(2^30 / FULL_SCALE), estimate is low by at most one
    localparam int RECIP_SHIFT = 30;
    localparam logic [20:0] RECIP_M = 21'((64'd1 << RECIP_SHIFT) / FULL_SCALE);
    localparam logic [28:0] REMAP_M = 29'(REMAP_SPAN * RECIP_M);

    // Pivot limit reset value
    localparam logic [CFG_W-1:0] PIVOT_LIMIT_RST = 10'd255;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_DEADBAND    = 1'b0,
        REG_PIVOT_LIMIT = 1'b1
    } t_cfg_reg;

    // Divider partial state: running remainder and quotient bits so far
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } t_div;

endpackage

`default_nettype wire

// ===== design/differential_drive_mixer_top.sv =====
`default_nettype none

// Channel   Dir   Beat fields (low bit first)
// s_axis    in    tdata: joy_x[10:0], joy_y[21:11], zero pad [23:22]
// m_axis    out   tdata: left_forward[0], left_duty[10:1], right_forward[11],
//                        right_duty[21:12], zero pad [23:22]
// cfg       in    index 0 deadband, index 1 pivot_limit; wdata[9:0]
//
// Fifteen register stages; one beat enters per cycle unless a stall on m_axis backs up to the input.
// The depth is set by the Q16 pivot-weight divider (four steps per stage) and the
// two reciprocal divisions by the full scale, each a multiply then a correction stage.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// A stall on m_axis fills empty stages first; nothing is dropped or repeated.
module differential_drive_mixer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // joy_x, joy_y, pad
    input  wire logic [ddm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // left_forward, left_duty, right_forward, right_duty, pad
    output logic [ddm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire ddm_pkg::t_cfg_reg                i_cfg_addr,
    input  wire logic [ddm_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import ddm_pkg::*;

    localparam int NSTG      = 15;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STG   = Q_FRAC / DIV_STEPS;
    localparam int PRD_W     = 21;
    localparam int NUM_W     = 39;
    localparam int T_W       = 20;

    localparam logic signed [AXIS_W-1:0] FS_AX = AXIS_W'(FULL_SCALE);
    localparam logic signed [PRD_W-1:0]  FS_PR = PRD_W'(FULL_SCALE);
    localparam logic [Q_W-1:0]           Q_ONE = Q_W'(1) << Q_FRAC;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_deadband;
    logic [CFG_W-1:0] r_pivot_limit;
    logic [CFG_W-1:0] lim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= '0;
            r_pivot_limit <= PIVOT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_DEADBAND:    r_deadband    <= i_cfg_wdata;
                REG_PIVOT_LIMIT: r_pivot_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Treat a zero limit as one
    assign lim = (r_pivot_limit == '0) ? CFG_W'(1) : r_pivot_limit;

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] en;
    logic [NSTG:1]   vld_in;

    always_comb begin
        en[NSTG+1] = m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign vld_in        = {r_vld[NSTG-1:1], s_axis_tvalid};
    assign s_axis_tready = en[1];
    assign m_axis_tvalid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (en[k]) r_vld[k] <= vld_in[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    function automatic logic signed [AXIS_W-1:0] sat_axis(input logic [AXIS_W-1:0] v);
        logic signed [AXIS_W-1:0] s;
        s = $signed(v);
        if (s < -FS_AX) s = -FS_AX;
        if (s > FS_AX)  s = FS_AX;
        return s;
    endfunction

    // Restoring division steps, one quotient bit each
    function automatic t_div div_steps(input t_div d, input logic [CFG_W-1:0] dv);
        t_div             o;
        logic [MAG_W:0]   sh;
        o = d;
        for (int i = 0; i < DIV_STEPS; i++) begin
            sh = {o.rem, 1'b0};
            if (sh >= {1'b0, dv}) begin
                o.rem = MAG_W'(sh - {1'b0, dv});
                o.quo = {o.quo[Q_W-2:0], 1'b1};
            end else begin
                o.rem = sh[MAG_W-1:0];
                o.quo = {o.quo[Q_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // ---------------------------------------------------------------
    // S1: saturate axes, throttle magnitude
    // ---------------------------------------------------------------
    logic signed [AXIS_W-1:0] n_s1_x, n_s1_y;
    logic signed [AXIS_W-1:0] r_s1_x, r_s1_y;
    logic [MAG_W-1:0]         r_s1_ay;
    logic signed [AXIS_W-1:0] n_s1_ny;

    assign n_s1_x  = sat_axis(s_axis_tdata[AXIS_W-1:0]);
    assign n_s1_y  = sat_axis(s_axis_tdata[2*AXIS_W-1:AXIS_W]);
    assign n_s1_ny = -n_s1_y;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_x  <= n_s1_x;
            r_s1_y  <= n_s1_y;
            r_s1_ay <= n_s1_y[AXIS_W-1] ? n_s1_ny[MAG_W-1:0] : n_s1_y[MAG_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // S2: premix, steering times full scale, integer divider bit
    // ---------------------------------------------------------------
    logic [AXIS_W-1:0]         fs_plus_x, fs_minus_x;
    logic [MAG_W-1:0]          n_s2_prel, n_s2_prer;
    logic                      x_pos, y_pos;
    logic signed [PRD_W-1:0]   x_ext;
    t_div                      n_s2_div;
    logic signed [AXIS_W-1:0]  r_s2_y;
    logic [MAG_W-1:0]          r_s2_prel, r_s2_prer;
    logic signed [PRD_W-1:0]   r_s2_xf;
    logic                      r_s2_over;
    t_div                      r_s2_div;

    assign x_pos      = !r_s1_x[AXIS_W-1];
    assign y_pos      = !r_s1_y[AXIS_W-1];
    assign fs_plus_x  = FS_AX + r_s1_x;
    assign fs_minus_x = FS_AX - r_s1_x;
    assign x_ext      = PRD_W'(r_s1_x);

    always_comb begin
        if (y_pos) begin
            n_s2_prel = x_pos ? MAG_W'(FULL_SCALE) : fs_plus_x[MAG_W-1:0];
            n_s2_prer = x_pos ? fs_minus_x[MAG_W-1:0] : MAG_W'(FULL_SCALE);
        end else begin
            n_s2_prel = x_pos ? fs_minus_x[MAG_W-1:0] : MAG_W'(FULL_SCALE);
            n_s2_prer = x_pos ? MAG_W'(FULL_SCALE) : fs_plus_x[MAG_W-1:0];
        end
        if (r_s1_ay >= lim) begin
            n_s2_div.rem = r_s1_ay - lim;
            n_s2_div.quo = Q_W'(1);
        end else begin
            n_s2_div.rem = r_s1_ay;
            n_s2_div.quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_y    <= r_s1_y;
            r_s2_prel <= n_s2_prel;
            r_s2_prer <= n_s2_prer;
            r_s2_xf   <= PRD_W'(x_ext * FS_PR);
            r_s2_over <= r_s1_ay > lim;
            r_s2_div  <= n_s2_div;
        end
    end

    // ---------------------------------------------------------------
    // S3..S6: fraction bits of |Y| / limit, drive products alongside
    // ---------------------------------------------------------------
    t_div                    r_dv      [DIV_STG];
    logic                    r_dv_over [DIV_STG];
    logic signed [PRD_W-1:0] r_dv_pyl  [DIV_STG];
    logic signed [PRD_W-1:0] r_dv_pyr  [DIV_STG];
    logic signed [PRD_W-1:0] r_dv_xf   [DIV_STG];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_dv[0]      <= div_steps(r_s2_div, lim);
            r_dv_over[0] <= r_s2_over;
            r_dv_pyl[0]  <= PRD_W'($signed({1'b0, r_s2_prel})) * PRD_W'(r_s2_y);
            r_dv_pyr[0]  <= PRD_W'($signed({1'b0, r_s2_prer})) * PRD_W'(r_s2_y);
            r_dv_xf[0]   <= r_s2_xf;
        end
        for (int d = 1; d < DIV_STG; d++) begin
            if (en[3+d]) begin
                r_dv[d]      <= div_steps(r_dv[d-1], lim);
                r_dv_over[d] <= r_dv_over[d-1];
                r_dv_pyl[d]  <= r_dv_pyl[d-1];
                r_dv_pyr[d]  <= r_dv_pyr[d-1];
                r_dv_xf[d]   <= r_dv_xf[d-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // S7: drive weight u = 1 - w and pivot weight w
    // ---------------------------------------------------------------
    localparam int S7 = 3 + DIV_STG;
    logic [Q_W-1:0]          n_s7_u;
    logic [Q_W-1:0]          r_s7_u, r_s7_w;
    logic signed [PRD_W-1:0] r_s7_pyl, r_s7_pyr, r_s7_xf;

    assign n_s7_u = r_dv_over[DIV_STG-1] ? Q_ONE : r_dv[DIV_STG-1].quo;

    always_ff @(posedge i_clk) begin
        if (en[S7]) begin
            r_s7_u   <= n_s7_u;
            r_s7_w   <= Q_ONE - n_s7_u;
            r_s7_pyl <= r_dv_pyl[DIV_STG-1];
            r_s7_pyr <= r_dv_pyr[DIV_STG-1];
            r_s7_xf  <= r_dv_xf[DIV_STG-1];
        end
    end

    // ---------------------------------------------------------------
    // S8: weighted products
    // ---------------------------------------------------------------
    logic signed [NUM_W-1:0] r_s8_al, r_s8_ar, r_s8_b;

    always_ff @(posedge i_clk) begin
        if (en[S7+1]) begin
            r_s8_al <= NUM_W'($signed({1'b0, r_s7_u})) * NUM_W'(r_s7_pyl);
            r_s8_ar <= NUM_W'($signed({1'b0, r_s7_u})) * NUM_W'(r_s7_pyr);
            r_s8_b  <= NUM_W'($signed({1'b0, r_s7_w})) * NUM_W'(r_s7_xf);
        end
    end

    // ---------------------------------------------------------------
    // S9: mix numerators
    // ---------------------------------------------------------------
    logic signed [NUM_W-1:0] r_s9_numl, r_s9_numr;

    always_ff @(posedge i_clk) begin
        if (en[S7+2]) begin
            r_s9_numl <= r_s8_al + r_s8_b;
            r_s9_numr <= r_s8_ar - r_s8_b;
        end
    end

    // ---------------------------------------------------------------
    // S10: sign and magnitude, drop the Q16 fraction
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] absl, absr;
    logic [T_W-1:0]   r_s10_tl, r_s10_tr;
    logic             r_s10_negl, r_s10_negr;

    assign absl = r_s9_numl[NUM_W-1] ? NUM_W'(-r_s9_numl) : NUM_W'(r_s9_numl);
    assign absr = r_s9_numr[NUM_W-1] ? NUM_W'(-r_s9_numr) : NUM_W'(r_s9_numr);

    always_ff @(posedge i_clk) begin
        if (en[S7+3]) begin
            r_s10_tl   <= absl[Q_FRAC+T_W-1:Q_FRAC];
            r_s10_tr   <= absr[Q_FRAC+T_W-1:Q_FRAC];
            r_s10_negl <= r_s9_numl[NUM_W-1];
            r_s10_negr <= r_s9_numr[NUM_W-1];
        end
    end

    // ---------------------------------------------------------------
    // S11: reciprocal multiply for the divide by full scale
    // ---------------------------------------------------------------
    localparam int PL_W = T_W + 21;
    logic [PL_W-1:0] r_s11_pl, r_s11_pr;
    logic [T_W-1:0]  r_s11_tl, r_s11_tr;
    logic            r_s11_negl, r_s11_negr;

    always_ff @(posedge i_clk) begin
        if (en[S7+4]) begin
            r_s11_pl   <= PL_W'(r_s10_tl) * PL_W'(RECIP_M);
            r_s11_pr   <= PL_W'(r_s10_tr) * PL_W'(RECIP_M);
            r_s11_tl   <= r_s10_tl;
            r_s11_tr   <= r_s10_tr;
            r_s11_negl <= r_s10_negl;
            r_s11_negr <= r_s10_negr;
        end
    end

    // ---------------------------------------------------------------
    // S12: correct the quotient estimate by one where the remainder overflows
    // ---------------------------------------------------------------
    function automatic logic [MAG_W-1:0] fix_quo(input logic [PL_W-1:0] p,
                                                 input logic [T_W-1:0] t);
        logic [MAG_W-1:0] est;
        logic [T_W:0]     back;
        logic [T_W:0]     rem;
        est  = p[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
        back = (T_W+1)'({est, 10'b0}) - (T_W+1)'(est);
        rem  = (T_W+1)'(t) - back;
        if (rem >= (T_W+1)'(FULL_SCALE)) est = est + 1'b1;
        return est;
    endfunction

    logic [MAG_W-1:0] r_s12_magl, r_s12_magr;
    logic             r_s12_negl, r_s12_negr;

    always_ff @(posedge i_clk) begin
        if (en[S7+5]) begin
            r_s12_magl <= fix_quo(r_s11_pl, r_s11_tl);
            r_s12_magr <= fix_quo(r_s11_pr, r_s11_tr);
            r_s12_negl <= r_s11_negl;
            r_s12_negr <= r_s11_negr;
        end
    end

    // ---------------------------------------------------------------
    // S13: direction, deadband, remap reciprocal multiply
    // ---------------------------------------------------------------
    localparam int P2_W = MAG_W + 29;
    logic [P2_W-1:0]  r_s13_p2l, r_s13_p2r;
    logic [MAG_W-1:0] r_s13_magl, r_s13_magr;
    logic             r_s13_fwdl, r_s13_fwdr, r_s13_keepl, r_s13_keepr;

    always_ff @(posedge i_clk) begin
        if (en[S7+6]) begin
            r_s13_p2l   <= P2_W'(r_s12_magl) * P2_W'(REMAP_M);
            r_s13_p2r   <= P2_W'(r_s12_magr) * P2_W'(REMAP_M);
            r_s13_magl  <= r_s12_magl;
            r_s13_magr  <= r_s12_magr;
            r_s13_fwdl  <= !r_s12_negl || (r_s12_magl == '0);
            r_s13_fwdr  <= !r_s12_negr || (r_s12_magr == '0);
            r_s13_keepl <= r_s12_magl > r_deadband;
            r_s13_keepr <= r_s12_magr > r_deadband;
        end
    end

    // ---------------------------------------------------------------
    // S14: correct the remap quotient
    // ---------------------------------------------------------------
    localparam int RM_W = MAG_W + 9;
    function automatic logic [8:0] fix_remap(input logic [P2_W-1:0] p,
                                             input logic [MAG_W-1:0] mag);
        logic [8:0]      est;
        logic [RM_W-1:0] full;
        logic [RM_W-1:0] back;
        logic [RM_W-1:0] rem;
        est  = p[RECIP_SHIFT+8:RECIP_SHIFT];
        full = RM_W'(mag) * RM_W'(REMAP_SPAN);
        back = RM_W'({est, 10'b0}) - RM_W'(est);
        rem  = full - back;
        if (rem >= RM_W'(FULL_SCALE)) est = est + 1'b1;
        return est;
    endfunction

    logic [8:0] r_s14_dl, r_s14_dr;
    logic       r_s14_fwdl, r_s14_fwdr, r_s14_keepl, r_s14_keepr;

    always_ff @(posedge i_clk) begin
        if (en[S7+7]) begin
            r_s14_dl    <= fix_remap(r_s13_p2l, r_s13_magl);
            r_s14_dr    <= fix_remap(r_s13_p2r, r_s13_magr);
            r_s14_fwdl  <= r_s13_fwdl;
            r_s14_fwdr  <= r_s13_fwdr;
            r_s14_keepl <= r_s13_keepl;
            r_s14_keepr <= r_s13_keepr;
        end
    end

    // ---------------------------------------------------------------
    // S15: PWM offset, cap, invert when forward; output register
    // ---------------------------------------------------------------
    function automatic logic [MAG_W-1:0] duty_of(input logic [8:0] d, input logic keep,
                                                 input logic fwd);
        logic [MAG_W:0]   sum;
        logic [MAG_W-1:0] m;
        sum = (MAG_W+1)'(PWM_MIN) + (MAG_W+1)'(d);
        if (!keep)                             m = '0;
        else if (sum > (MAG_W+1)'(PWM_MAX))    m = MAG_W'(PWM_MAX);
        else                                   m = sum[MAG_W-1:0];
        return fwd ? (MAG_W'(PWM_MAX) - m) : m;
    endfunction

    logic             r_s15_fwdl, r_s15_fwdr;
    logic [MAG_W-1:0] r_s15_dutyl, r_s15_dutyr;

    always_ff @(posedge i_clk) begin
        if (en[S7+8]) begin
            r_s15_fwdl  <= r_s14_fwdl;
            r_s15_fwdr  <= r_s14_fwdr;
            r_s15_dutyl <= duty_of(r_s14_dl, r_s14_keepl, r_s14_fwdl);
            r_s15_dutyr <= duty_of(r_s14_dr, r_s14_keepr, r_s14_fwdr);
        end
    end

    assign m_axis_tdata = {2'b00, r_s15_dutyr, r_s15_fwdr, r_s15_dutyl, r_s15_fwdl};

endmodule

`default_nettype wire

// ===== tb/sv/tb_differential_drive_mixer_top.sv =====
`default_nettype none

module tb_differential_drive_mixer_top;
    import ddm_pkg::*;

    // One motor command beat, laid out as m_axis_tdata[21:0]
    typedef struct packed {
        logic [MAG_W-1:0] right_duty;
        logic             right_fwd;
        logic [MAG_W-1:0] left_duty;
        logic             left_fwd;
    } t_motor_cmd;

    // Directed joystick sample, optionally with a hand-written expected command
    typedef struct {
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        bit                typed;
        t_motor_cmd        cmd;
    } t_joy_row;

    localparam int STALL_LIMIT  = 1000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 235;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_reg               i_cfg_addr = REG_DEADBAND;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    // Register copies, updated on each accepted write
    logic [CFG_W-1:0]       cur_deadband = '0;
    logic [CFG_W-1:0]       cur_pivot_limit = PIVOT_LIMIT_RST;

    t_motor_cmd             pending_cmds[$];
    t_joy_row               joy_rows[$];
    int                     mismatch_count = 0;
    int                     burst_left = 0;
    int                     quiet_cycles = 0;
    int                     stall_tick = 0;
    int                     stall_mode = 0;

    differential_drive_mixer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a raw axis reading to the symmetric full-scale range
    function automatic longint clamp_axis(logic [AXIS_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > FULL_SCALE) v = FULL_SCALE;
        if (v < -FULL_SCALE) v = -FULL_SCALE;
        return v;
    endfunction

    // Direction bit and PWM compare value for one motor: {duty, forward}
    function automatic logic [MAG_W:0] motor_out(longint mix);
        longint mag;
        longint m;
        logic   fwd;
        fwd = (mix >= 0);
        mag = fwd ? mix : -mix;
        m = 0;
        if (mag > longint'(cur_deadband)) begin
            m = PWM_MIN + (mag * REMAP_SPAN) / FULL_SCALE;
            if (m > PWM_MAX) m = PWM_MAX;
        end
        return {fwd ? MAG_W'(PWM_MAX - m) : MAG_W'(m), fwd};
    endfunction

    // Blend drive and pivot terms into left and right motor commands
    function automatic t_motor_cmd mix_joystick(logic [AXIS_W-1:0] rx, logic [AXIS_W-1:0] ry);
        longint fs, x, y, ay, lim, w, pre_l, pre_r, num_l, num_r, den;
        logic [MAG_W:0] left_cmd, right_cmd;
        fs = FULL_SCALE;
        x = clamp_axis(rx);
        y = clamp_axis(ry);
        ay = (y < 0) ? -y : y;
        lim = (cur_pivot_limit == 0) ? 1 : longint'(cur_pivot_limit);
        if (y >= 0) begin
            pre_l = (x >= 0) ? fs : fs + x;
            pre_r = (x >= 0) ? fs - x : fs;
        end else begin
            pre_l = (x >= 0) ? fs - x : fs;
            pre_r = (x >= 0) ? fs : fs + x;
        end
        w = (ay > lim) ? 0 : 65536 - (ay * 65536) / lim;
        den = 65536 * fs;
        num_l = (65536 - w) * pre_l * y + w * x * fs;
        num_r = (65536 - w) * pre_r * y - w * x * fs;
        left_cmd = motor_out(num_l / den);
        right_cmd = motor_out(num_r / den);
        return {right_cmd, left_cmd};
    endfunction

    // Send one joystick beat, opening a new burst after a random gap when due
    task automatic send_joy(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                            input bit typed, input t_motor_cmd typed_cmd);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_cmds.push_back(typed ? typed_cmd : mix_joystick(x, y));
    endtask

    // Drop valid and hold until every outstanding command has come back
    task automatic drain_joy();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg addr, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (addr == REG_DEADBAND) cur_deadband = value;
        else cur_pivot_limit = value;
    endtask

    // Write both registers in random order, then release the channel
    task automatic set_config(input logic [CFG_W-1:0] dz, input logic [CFG_W-1:0] pl);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_DEADBAND, dz);
            write_reg(REG_PIVOT_LIMIT, pl);
        end else begin
            write_reg(REG_PIVOT_LIMIT, pl);
            write_reg(REG_DEADBAND, dz);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver stall pattern: switch at random among always ready, coin-flip ready and two periodic patterns
    always @(negedge i_clk) begin
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (stall_tick % 4 != 0);
            default: m_axis_tready <= (stall_tick % 16 >= 12);
        endcase
        stall_tick++;
    end

    // Compare each returned beat against the oldest pending command
    always @(posedge i_clk) begin : check_results
        t_motor_cmd got;
        t_motor_cmd want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[21:0];
            if (pending_cmds.size() == 0) begin
                $error("unexpected motor beat: tdata=%h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (got.left_fwd !== want.left_fwd) begin
                    $error("left_forward: expected %0d, got %0d", want.left_fwd, got.left_fwd);
                    mismatch_count++;
                end
                if (got.left_duty !== want.left_duty) begin
                    $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
                    mismatch_count++;
                end
                if (got.right_fwd !== want.right_fwd) begin
                    $error("right_forward: expected %0d, got %0d",
                           want.right_fwd, got.right_fwd);
                    mismatch_count++;
                end
                if (got.right_duty !== want.right_duty) begin
                    $error("right_duty: expected %0d, got %0d",
                           want.right_duty, got.right_duty);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int axis_corners[6];
        int xv;
        int yv;
        int sel;
        logic [CFG_W-1:0] dz;
        logic [CFG_W-1:0] pl;

        axis_corners = '{-1024, -1023, -1, 0, 1, 1023};

        // Directed rows at reset settings (deadband 0, pivot limit 255)
        joy_rows.push_back('{11'd0, 11'd0, 1'b1, '{10'd1023, 1'b1, 10'd1023, 1'b1}});
        joy_rows.push_back('{11'd0, 11'd1023, 1'b1, '{10'd0, 1'b1, 10'd0, 1'b1}});
        joy_rows.push_back('{11'd0, -11'sd1023, 1'b1, '{10'd1023, 1'b0, 10'd1023, 1'b0}});
        joy_rows.push_back('{11'd0, 11'h400, 1'b1, '{10'd1023, 1'b0, 10'd1023, 1'b0}});
        joy_rows.push_back('{11'd1023, 11'd0, 1'b1, '{10'd1023, 1'b0, 10'd0, 1'b1}});
        joy_rows.push_back('{-11'sd1023, 11'd0, 1'b1, '{10'd0, 1'b1, 10'd1023, 1'b0}});
        joy_rows.push_back('{11'h400, 11'd0, 1'b1, '{10'd0, 1'b1, 10'd1023, 1'b0}});
        joy_rows.push_back('{11'd1023, 11'd1023, 1'b0, '0});
        joy_rows.push_back('{11'd1023, -11'sd1023, 1'b0, '0});
        joy_rows.push_back('{-11'sd1023, 11'd1023, 1'b0, '0});
        joy_rows.push_back('{11'h400, 11'h400, 1'b0, '0});
        joy_rows.push_back('{11'd0, 11'd255, 1'b0, '0});
        joy_rows.push_back('{11'd300, 11'd256, 1'b0, '0});
        joy_rows.push_back('{11'd100, 11'd254, 1'b0, '0});
        joy_rows.push_back('{-11'sd100, -11'sd255, 1'b0, '0});
        joy_rows.push_back('{11'd1, 11'd1, 1'b0, '0});
        joy_rows.push_back('{-11'sd1, -11'sd1, 1'b0, '0});
        joy_rows.push_back('{11'h555, 11'h2AA, 1'b0, '0});
        joy_rows.push_back('{11'h2AA, 11'h555, 1'b0, '0});
        joy_rows.push_back('{11'd512, -11'sd300, 1'b0, '0});
        joy_rows.push_back('{-11'sd700, 11'd128, 1'b0, '0});

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (joy_rows[i]) send_joy(joy_rows[i].x, joy_rows[i].y, joy_rows[i].typed,
                                       joy_rows[i].cmd);
        drain_joy();

        // Random phases: fixed settings first, extremes among them, then random settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin dz = 10'd0;    pl = 10'd0;    end
                1: begin dz = 10'd1023; pl = 10'd1;    end
                2: begin dz = 10'd0;    pl = 10'd1023; end
                3: begin dz = 10'd5;    pl = 10'd1;    end
                4: begin dz = 10'd40;   pl = 10'd100;  end
                default: begin
                    dz = CFG_W'($urandom_range(0, 60));
                    pl = CFG_W'($urandom_range(0, 1023));
                end
            endcase
            set_config(dz, pl);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 7);
                case (sel)
                    0, 1: begin
                        xv = $urandom_range(0, 2047);
                        yv = $urandom_range(0, 2047);
                    end
                    2: begin
                        // throttle right around the pivot limit
                        xv = int'($urandom_range(0, 2046)) - 1023;
                        yv = int'(cur_pivot_limit) + int'($urandom_range(0, 4)) - 2;
                        if (yv > 1023) yv = 1023;
                        if ($urandom_range(0, 1) == 1) yv = -yv;
                    end
                    3: begin
                        xv = axis_corners[$urandom_range(0, 5)];
                        yv = axis_corners[$urandom_range(0, 5)];
                    end
                    4: begin
                        xv = int'($urandom_range(0, 48)) - 24;
                        yv = int'($urandom_range(0, 48)) - 24;
                    end
                    default: begin
                        xv = int'($urandom_range(0, 2046)) - 1023;
                        yv = int'($urandom_range(0, 2046)) - 1023;
                    end
                endcase
                send_joy(xv[AXIS_W-1:0], yv[AXIS_W-1:0], 1'b0, '0);
            end
            drain_joy();
        end

        // Let the pipeline settle past its depth before the verdict
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ddm_pkg.sv
design/differential_drive_mixer_top.sv
tb/sv/tb_differential_drive_mixer_top.sv
